### rtl/core/adsr_envelope_generator_assert.svh
// Assertion macros for the envelope generator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define ADSR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in a cycle implies the consequent in the next cycle.
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/adsr_pkg.sv
package adsr_pkg;

	localparam int TIME_BITS = 24;
	localparam int LEVEL_BITS = 16;

	localparam int PROD_BITS = TIME_BITS + LEVEL_BITS;
	localparam int ACC_BITS = PROD_BITS + 1;
	localparam int CNT_BITS = $clog2(LEVEL_BITS);

	localparam int IN_DATA_BITS = 8;
	localparam int OUT_DATA_BITS = ((LEVEL_BITS + 7) / 8) * 8;
	localparam int CFG_DATA_BITS = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOUND = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN = 3'd5;

	localparam logic [LEVEL_BITS-1:0] PEAK_RESET = {LEVEL_BITS{1'b1}};
	localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET = {1'b1, {(LEVEL_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_ATTACK,
		OP_DECAY,
		OP_RELEASE
	} ramp_op_t;

	typedef enum logic [1:0] {
		LVL_ZERO,
		LVL_SUSTAIN,
		LVL_QUOT
	} level_sel_t;

	typedef struct packed {
		logic advance;
		logic restart;
		logic op_load;
		ramp_op_t op;
		logic mul_first;
		logic mul_second;
		logic acc_add;
		logic div_start;
		logic div_step;
		logic out_load;
		level_sel_t level_sel;
		logic out_active;
		logic out_done;
	} dp_cmd_t;

	typedef struct packed {
		logic t_lt_attack;
		logic in_decay;
		logic sustain_hold;
		logic release_live;
		logic note_end;
		logic div_last;
	} dp_status_t;

endpackage

### rtl/core/adsr_envelope_generator.sv
// Channel  Direction  Handshake                Payload
// s_*      in         s_tvalid / s_tready      s_tdata: retrigger in bit 0
// m_*      out        m_tvalid / m_tready      m_tdata: envelope_level, m_tuser, m_tlast
// cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Items are handled one at a time. An idle voice goes straight to the output; a held
// level (sustain or zero) first walks the phase states; a ramp adds two multiplier
// steps, an add and the 16-step serial divider (one step per quotient bit).
// Reset is asynchronous; the arithmetic and level registers have no reset and start unknown.
// A stalled result register holds the next item in its last state until taken.
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [adsr_pkg::IN_DATA_BITS-1:0] s_tdata, // [0] retrigger
	output logic m_tvalid,
	input logic m_tready,
	output logic [adsr_pkg::OUT_DATA_BITS-1:0] m_tdata, // envelope_level
	output logic m_tuser, // voice_active
	output logic m_tlast, // note_done
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import adsr_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	logic [LEVEL_BITS-1:0] level;

	assign cfg_ready = 1'b1;

	adsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.retrigger(s_tdata[0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd(cmd),
		.status(status)
	);

	adsr_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.level(level),
		.active(m_tuser),
		.done(m_tlast)
	);

	assign m_tdata = OUT_DATA_BITS'(level);

	`ADSR_ASSERT_SAME(a_done_needs_active, m_tvalid && m_tlast, m_tuser, "done while idle")
	`ADSR_ASSERT_SAME(a_idle_level_zero, m_tvalid && !m_tuser, m_tdata == '0, "idle level")
	`ADSR_ASSERT_SAME(a_no_accept_in_divide, cmd.div_step, !s_tready, "ready in divide")
	`ADSR_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready, "back to back")

endmodule

### rtl/core/adsr_datapath.sv
module adsr_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input adsr_pkg::dp_cmd_t cmd,
	output adsr_pkg::dp_status_t status,
	output logic [adsr_pkg::LEVEL_BITS-1:0] level,
	output logic active,
	output logic done
);
	import adsr_pkg::*;

	logic [TIME_BITS-1:0] attack_q, decay_q, release_q, sound_q;
	logic [LEVEL_BITS-1:0] peak_q, sustain_q;
	logic [TIME_BITS-1:0] elapsed_q;
	ramp_op_t op_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [TIME_BITS-1:0] divisor_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [LEVEL_BITS-1:0] quot_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic active_q, done_q;

	logic [TIME_BITS-1:0] t_base, dt, dec_span, rel_span;
	logic [TIME_BITS:0] t_plus_r;
	logic [TIME_BITS-1:0] mul_a;
	logic [LEVEL_BITS-1:0] mul_b;
	logic [PROD_BITS-1:0] prod;
	logic [TIME_BITS:0] rem_sh, rem_diff;
	logic rem_ge;

	assign dt = elapsed_q - attack_q;
	assign dec_span = decay_q - dt;
	assign rel_span = sound_q - elapsed_q;
	assign t_plus_r = {1'b0, elapsed_q} + {1'b0, release_q};

	assign status.t_lt_attack = elapsed_q < attack_q;
	assign status.in_decay = (elapsed_q >= attack_q) && (dt < decay_q);
	assign status.sustain_hold = (elapsed_q > sound_q) || (rel_span >= release_q);
	assign status.release_live = (release_q != '0) && (elapsed_q < sound_q) &&
		(t_plus_r > {1'b0, sound_q});
	assign status.note_end = elapsed_q >= sound_q;
	assign status.div_last = cnt_q == CNT_BITS'(LEVEL_BITS - 1);

	assign t_base = cmd.restart ? '0 : elapsed_q;

	// second product only exists for the decay blend
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_second) begin
			if (op_q == OP_DECAY) begin
				mul_a = dt;
				mul_b = sustain_q;
			end
		end else begin
			unique case (op_q)
				OP_ATTACK: begin
					mul_a = elapsed_q;
					mul_b = peak_q;
				end
				OP_DECAY: begin
					mul_a = dec_span;
					mul_b = peak_q;
				end
				OP_RELEASE: begin
					mul_a = rel_span;
					mul_b = sustain_q;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

	// restoring divider, one quotient bit per step
	assign rem_sh = {rem_q, quot_q[LEVEL_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign rem_ge = rem_sh >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= '0;
			decay_q <= '0;
			release_q <= '0;
			sound_q <= '0;
			peak_q <= PEAK_RESET;
			sustain_q <= SUSTAIN_RESET;
			elapsed_q <= '0;
			op_q <= OP_ATTACK;
			cnt_q <= '0;
			active_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ATTACK: attack_q <= cfg_data[TIME_BITS-1:0];
					REG_DECAY: decay_q <= cfg_data[TIME_BITS-1:0];
					REG_RELEASE: release_q <= cfg_data[TIME_BITS-1:0];
					REG_SOUND: sound_q <= cfg_data[TIME_BITS-1:0];
					REG_PEAK: peak_q <= cfg_data[LEVEL_BITS-1:0];
					REG_SUSTAIN: sustain_q <= cfg_data[LEVEL_BITS-1:0];
					default: ;
				endcase
			end
			// saturate at the top of the counter
			if (cmd.advance) begin
				elapsed_q <= (t_base == {TIME_BITS{1'b1}}) ? t_base : t_base + 1'b1;
			end
			if (cmd.op_load) begin
				op_q <= cmd.op;
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				active_q <= cmd.out_active;
				done_q <= cmd.out_done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_first || cmd.mul_second) begin
			prod_q <= prod;
		end
		if (cmd.mul_second) begin
			acc_q <= {1'b0, prod_q};
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + {1'b0, prod_q};
		end
		// numerator stays below divisor * 2^LEVEL_BITS, so the top part fits
		if (cmd.div_start) begin
			unique case (op_q)
				OP_ATTACK: divisor_q <= attack_q;
				OP_DECAY: divisor_q <= decay_q;
				OP_RELEASE: divisor_q <= release_q;
				default: divisor_q <= release_q;
			endcase
			rem_q <= acc_q[LEVEL_BITS+TIME_BITS-1:LEVEL_BITS];
			quot_q <= acc_q[LEVEL_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
			quot_q <= {quot_q[LEVEL_BITS-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			unique case (cmd.level_sel)
				LVL_ZERO: level_q <= '0;
				LVL_SUSTAIN: level_q <= sustain_q;
				LVL_QUOT: level_q <= quot_q;
				default: level_q <= '0;
			endcase
		end
	end

	assign level = level_q;
	assign active = active_q;
	assign done = done_q;

endmodule

### rtl/core/adsr_ctrl.sv
module adsr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic retrigger,
	output logic m_tvalid,
	input logic m_tready,
	output adsr_pkg::dp_cmd_t cmd,
	input adsr_pkg::dp_status_t status
);
	import adsr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ATTACK,
		S_DECAY,
		S_SUSTAIN,
		S_RELEASE,
		S_MUL1,
		S_MUL2,
		S_ADD,
		S_DIVLD,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_ATTACK,
		PH_DECAY,
		PH_SUSTAIN,
		PH_RELEASE
	} phase_t;

	state_t state_q;
	phase_t phase_q, phase_eff;
	logic running_q, active_q, m_tvalid_q;
	level_sel_t level_sel_q;
	logic run_w, out_free;

	assign run_w = retrigger || running_q;
	assign phase_eff = retrigger ? PH_ATTACK : phase_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd = '0;
		cmd.level_sel = level_sel_q;
		cmd.out_active = active_q;
		cmd.out_done = active_q && status.note_end;
		unique case (state_q)
			S_IDLE: begin
				cmd.advance = s_tvalid && run_w;
				cmd.restart = retrigger;
			end
			S_ATTACK: begin
				cmd.op = OP_ATTACK;
				cmd.op_load = status.t_lt_attack;
			end
			S_DECAY: begin
				cmd.op = OP_DECAY;
				cmd.op_load = status.in_decay;
			end
			S_SUSTAIN: ;
			S_RELEASE: begin
				cmd.op = OP_RELEASE;
				cmd.op_load = status.release_live;
			end
			S_MUL1: cmd.mul_first = 1'b1;
			S_MUL2: cmd.mul_second = 1'b1;
			S_ADD: cmd.acc_add = 1'b1;
			S_DIVLD: cmd.div_start = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_OUT: cmd.out_load = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_ATTACK;
			running_q <= 1'b0;
			active_q <= 1'b0;
			level_sel_q <= LVL_ZERO;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (retrigger) begin
							phase_q <= PH_ATTACK;
							running_q <= 1'b1;
						end
						active_q <= run_w;
						if (run_w) begin
							unique case (phase_eff)
								PH_ATTACK: state_q <= S_ATTACK;
								PH_DECAY: state_q <= S_DECAY;
								PH_SUSTAIN: state_q <= S_SUSTAIN;
								PH_RELEASE: state_q <= S_RELEASE;
							endcase
						end else begin
							level_sel_q <= LVL_ZERO;
							state_q <= S_OUT;
						end
					end
				end
				// fall through empty phases within the same item
				S_ATTACK: begin
					if (status.t_lt_attack) begin
						level_sel_q <= LVL_QUOT;
						state_q <= S_MUL1;
					end else begin
						phase_q <= PH_DECAY;
						state_q <= S_DECAY;
					end
				end
				S_DECAY: begin
					if (status.in_decay) begin
						level_sel_q <= LVL_QUOT;
						state_q <= S_MUL1;
					end else begin
						phase_q <= PH_SUSTAIN;
						state_q <= S_SUSTAIN;
					end
				end
				S_SUSTAIN: begin
					if (status.sustain_hold) begin
						level_sel_q <= LVL_SUSTAIN;
						state_q <= S_OUT;
					end else begin
						phase_q <= PH_RELEASE;
						state_q <= S_RELEASE;
					end
				end
				S_RELEASE: begin
					if (status.release_live) begin
						level_sel_q <= LVL_QUOT;
						state_q <= S_MUL1;
					end else begin
						level_sel_q <= LVL_ZERO;
						state_q <= S_OUT;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ADD;
				S_ADD: state_q <= S_DIVLD;
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (status.div_last) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (active_q && status.note_end) begin
							running_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import adsr_pkg::*;

	typedef enum logic [1:0] {
		ENV_ATTACK,
		ENV_DECAY,
		ENV_SUSTAIN,
		ENV_RELEASE
	} env_phase_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic active;
		logic done;
	} env_sample_t;

	class envelope_scoreboard;
		logic [TIME_BITS-1:0] attack_len;
		logic [TIME_BITS-1:0] decay_len;
		logic [TIME_BITS-1:0] release_len;
		logic [TIME_BITS-1:0] sound_len;
		logic [LEVEL_BITS-1:0] peak;
		logic [LEVEL_BITS-1:0] sustain;
		logic [TIME_BITS-1:0] elapsed;
		env_phase_t phase;
		logic running;
		env_sample_t samples[$];
		int failures;
		int reported;

		function new();
			attack_len = '0;
			decay_len = '0;
			release_len = '0;
			sound_len = '0;
			peak = PEAK_RESET;
			sustain = SUSTAIN_RESET;
			elapsed = '0;
			phase = ENV_ATTACK;
			running = 1'b0;
			failures = 0;
			reported = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_ATTACK: attack_len = val[TIME_BITS-1:0];
				REG_DECAY: decay_len = val[TIME_BITS-1:0];
				REG_RELEASE: release_len = val[TIME_BITS-1:0];
				REG_SOUND: sound_len = val[TIME_BITS-1:0];
				REG_PEAK: peak = val[LEVEL_BITS-1:0];
				REG_SUSTAIN: sustain = val[LEVEL_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Walk the phases forward from where the note stands; a phase that is
		// already over falls through to the next one in the same tick.
		function logic [LEVEL_BITS-1:0] level_at(longint unsigned t);
			longint unsigned a, d, r, dur, pk, su, dt, x;
			a = 64'(attack_len);
			d = 64'(decay_len);
			r = 64'(release_len);
			dur = 64'(sound_len);
			pk = 64'(peak);
			su = 64'(sustain);
			if (phase == ENV_ATTACK) begin
				if (t < a)
					return LEVEL_BITS'((t * pk) / a);
				phase = ENV_DECAY;
			end
			if (phase == ENV_DECAY) begin
				if (t >= a) begin
					dt = t - a;
					if (dt < d)
						return LEVEL_BITS'((pk * (d - dt) + su * dt) / d);
				end
				phase = ENV_SUSTAIN;
			end
			if (phase == ENV_SUSTAIN) begin
				if (t > dur || dur - t >= r)
					return LEVEL_BITS'(su);
				phase = ENV_RELEASE;
			end
			if (r == 0 || t + r <= dur)
				return '0;
			x = t + r - dur;
			if (x >= r)
				return '0;
			return LEVEL_BITS'((su * (r - x)) / r);
		endfunction

		function void accept_tick(logic retrig);
			env_sample_t s;
			s = '0;
			if (retrig) begin
				elapsed = '0;
				phase = ENV_ATTACK;
				running = 1'b1;
			end
			if (running) begin
				if (elapsed != {TIME_BITS{1'b1}})
					elapsed = elapsed + 1'b1;
				s.level = level_at(64'(elapsed));
				s.active = 1'b1;
				if (elapsed >= sound_len) begin
					s.done = 1'b1;
					running = 1'b0;
				end
			end
			samples.push_back(s);
		endfunction

		function void check_sample(logic [LEVEL_BITS-1:0] level, logic active, logic done);
			env_sample_t want;
			if (samples.size() == 0) begin
				failures++;
				if (reported < 10)
					$display("unexpected sample: level %0d active %0b done %0b",
						level, active, done);
				reported++;
				return;
			end
			want = samples.pop_front();
			if (want.level !== level || want.active !== active || want.done !== done) begin
				failures++;
				if (reported < 10)
					$display("mismatch: level %0d/%0d active %0b/%0b done %0b/%0b (exp/got)",
						want.level, level, want.active, active, want.done, done);
				reported++;
			end
		endfunction

		function int pending();
			return samples.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_BITS-1:0] s_tdata; // [0] retrigger
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata; // [15:0] envelope_level
	logic m_tuser; // voice_active
	logic m_tlast; // note_done
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	envelope_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int hold_reqs;
	logic [TIME_BITS-1:0] cur_sound;

	adsr_envelope_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random backpressure, plus a long hold-off whenever one is requested.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_sample(m_tdata[LEVEL_BITS-1:0], m_tuser, m_tlast);
			if (s_tvalid && s_tready)
				sb.accept_tick(s_tdata[0]);
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
		end
	end

	// Keep tvalid steady across back-to-back transfers; drop it only for a gap.
	task automatic send_tick(input logic retrig);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_BITS-1){1'b0}}, retrig};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_profile(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] d,
			input logic [TIME_BITS-1:0] r, input logic [TIME_BITS-1:0] s,
			input logic [LEVEL_BITS-1:0] pk, input logic [LEVEL_BITS-1:0] su);
		cfg_write(REG_ATTACK, CFG_DATA_BITS'(a));
		cfg_write(REG_DECAY, CFG_DATA_BITS'(d));
		cfg_write(REG_RELEASE, CFG_DATA_BITS'(r));
		cfg_write(REG_SOUND, CFG_DATA_BITS'(s));
		cfg_write(REG_PEAK, CFG_DATA_BITS'(pk));
		cfg_write(REG_SUSTAIN, CFG_DATA_BITS'(su));
		cfg_close();
		cur_sound = s;
	endtask

	function automatic logic [TIME_BITS-1:0] pick_len(input int unsigned hi);
		int unsigned r;
		r = $urandom_range(15);
		if (r < 2)
			return '0;
		if (r == 2)
			return '1;
		return TIME_BITS'($urandom_range(hi, 1));
	endfunction

	function automatic logic [LEVEL_BITS-1:0] pick_level();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return LEVEL_BITS'($urandom_range(16'hFFFF));
	endfunction

	// Mostly whole notes from retrigger to done, the rest random ticks.
	task automatic run_phase(input int n_items);
		int left;
		int ticks;
		left = n_items;
		while (left > 0) begin
			if ($urandom_range(99) < 80) begin
				ticks = (cur_sound > 40) ? 40 : int'(cur_sound);
				ticks = ticks + int'($urandom_range(2));
				send_tick(1'b1);
				left--;
				while (ticks > 1 && left > 0) begin
					send_tick(1'b0);
					ticks--;
					left--;
				end
			end else begin
				send_tick($urandom_range(99) < 30);
				left--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_reqs = 0;
		cur_sound = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle voice, then a zero-duration note on reset settings
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);

		// full note through every phase, then one tick past its end
		settle();
		write_profile(24'd3, 24'd2, 24'd2, 24'd10, 16'hFFFF, 16'd20000);
		send_tick(1'b1);
		repeat (10) send_tick(1'b0);

		// zero-length attack, decay and release
		settle();
		write_profile(24'd0, 24'd0, 24'd0, 24'd3, 16'd0, 16'hFFFF);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);

		// attack and then duration moved under a running note
		settle();
		write_profile(24'd2, 24'd4, 24'd0, 24'd20, 16'd40000, 16'd1000);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		settle();
		cfg_write(REG_ATTACK, '1);
		cfg_close();
		send_tick(1'b0);
		settle();
		cfg_write(REG_SOUND, CFG_DATA_BITS'(2));
		cfg_close();
		send_tick(1'b0);

		for (int p = 0; p < 13; p++) begin
			settle();
			if (p == 0) begin
				send_idle_pct = 15;
				recv_idle_pct <= 67;
			end else if (p == 4) begin
				send_idle_pct = 67;
				recv_idle_pct <= 15;
			end else if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			write_profile(pick_len(12), pick_len(12), pick_len(12), pick_len(40),
				pick_level(), pick_level());
			// stall the output long enough for the input side to back up
			if (p == 2 || p == 9)
				hold_reqs <= hold_reqs + 1;
			run_phase(42);
		end

		settle();
		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/adsr_pkg.sv
rtl/core/adsr_datapath.sv
rtl/core/adsr_ctrl.sv
rtl/core/adsr_envelope_generator.sv
sim/tb.sv
